// ----- rtl/ogrm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy grid running mean package
// Shared item types, operation codes and register indexes.
// ----------------------------------------------------------------------------
package ogrm_pkg;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] REG_WIDTH     = 3'd0;
    localparam logic [2:0] REG_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_INTERVAL  = 3'd2;
    localparam logic [2:0] REG_NEAR_SKIP = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_WARMUP    = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [7:0]  raw_intensity;
        logic [15:0] point_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [15:0] hit_count;
        logic        pixel_written;
        logic        map_ready;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic clr_step;
        logic clr_done_set;
        logic rd_issue;
        logic div_start;
        logic wr_issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic pass_due;
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/occupancy_grid_running_mean.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy grid running mean
// Per-pixel cumulative average of binarized sonar hits with hit counters.
// ----------------------------------------------------------------------------
// Items enter on i_in_valid/o_in_stall and each gives one result item on
// o_out_valid/i_out_stall. Operations are update, read, clear and no-op.
// Every item runs a store read, a setup step, a serial divider that makes
// one quotient bit per cycle, a write and a finish step; the result is
// then loaded into the output register. Items are taken one at a time:
// the next item is accepted only after the previous one has finished and
// its result has been taken from the output register.
// A clear bumps a 4-bit epoch kept with every entry, so older entries read
// as zero; every sixteenth clear wraps the epoch and is followed by a
// clearing pass over all MAX_WIDTH*MAX_HEIGHT entries that stalls the input.
// After reset the same pass writes every entry, one per cycle, before the
// first item is taken; configuration writes are accepted at any time through
// i_cfg_valid/o_cfg_ready. The result sits in an output register; while the
// receiver stalls it holds, and a new item waits until it has been taken.
// ----------------------------------------------------------------------------
module occupancy_grid_running_mean
    import ogrm_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int HIT_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cmd      cmd;
    t_status   status;
    t_out_item result;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_cfg_ready = 1'b1;

    ogrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_full (r_out_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ogrm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .HIT_BITS   (HIT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.finish) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall)
        else $error("item accepted while result pending");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !r_out_valid)
        else $error("result overwritten");

    a_written_is_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.pixel_written) |-> (o_out_item.hit_count != 16'd0))
        else $error("written pixel with zero count");

endmodule
`default_nettype wire

// ----- rtl/ogrm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy grid running mean controller
// Sequences the clearing pass, store reads, the divider and write back.
// ----------------------------------------------------------------------------
module ogrm_ctrl
    import ogrm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_full,
    input  wire t_status i_status,
    output logic         o_in_stall,
    output t_cmd         o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_DATA  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    o_cmd.clr_done_set = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = i_out_full;
                if (i_in_valid && !i_out_full) begin
                    o_cmd.start = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_DATA;
            end
            S_DATA: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_issue = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                if (i_status.pass_due) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/ogrm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy grid running mean datapath
// Pixel and hit stores, epoch clear, point counter and serial divider.
// ----------------------------------------------------------------------------
module ogrm_datapath
    import ogrm_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int HIT_BITS   = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_item   i_item,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_cfg_valid,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output t_status         o_status,
    output t_out_item       o_result
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AB = $clog2(CELLS);
    localparam int EB = 4;
    localparam int NB = HIT_BITS + 1;
    localparam int DB = NB + 8;
    localparam int CB = $clog2(DB);
    localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

    logic [8:0]  r_map_width, r_map_height;
    logic [15:0] r_interval, r_near_skip, r_warmup;
    logic [7:0]  r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 9'd256;
            r_map_height <= 9'd256;
            r_interval   <= 16'd10;
            r_near_skip  <= 16'd0;
            r_threshold  <= 8'd20;
            r_warmup     <= 16'd300;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:     r_map_width  <= i_cfg_data[8:0];
                REG_HEIGHT:    r_map_height <= i_cfg_data[8:0];
                REG_INTERVAL:  r_interval   <= i_cfg_data;
                REG_NEAR_SKIP: r_near_skip  <= i_cfg_data;
                REG_THRESHOLD: r_threshold  <= i_cfg_data[7:0];
                REG_WARMUP:    r_warmup     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Each entry carries an epoch mark; entries from an older epoch read as zero.
    // When the epoch wraps, a clearing pass zeroes every entry again.
    logic [7:0]          r_pix_mem [CELLS];
    logic [HIT_BITS-1:0] r_hit_mem [CELLS];
    logic [EB-1:0]       r_ep_mem  [CELLS];
    logic [EB-1:0]       r_epoch;
    logic [AB-1:0]       r_clr_addr;

    t_in_item            r_item;
    logic                r_in_store;
    logic [AB-1:0]       r_addr;
    logic [7:0]          r_rd_pix;
    logic [HIT_BITS-1:0] r_rd_hit;
    logic [EB-1:0]       r_rd_ep;
    logic [15:0]         r_counter;
    logic                r_warm;

    logic in_store;
    assign in_store = (32'(i_item.column) < 32'(MAX_WIDTH))
                   && (32'(i_item.row) < 32'(MAX_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item     <= i_item;
            r_in_store <= in_store;
            r_addr     <= AB'(i_item.row) * AB'(MAX_WIDTH) + AB'(i_item.column);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_epoch    <= '0;
        end else begin
            if (i_cmd.clr_done_set) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.finish && r_item.operation == OP_CLEAR) begin
                r_epoch <= r_epoch + 1'b1;
            end
        end
    end

    assign o_status.clr_last = (r_clr_addr == AB'(CELLS - 1));
    assign o_status.pass_due = (r_item.operation == OP_CLEAR) && (r_epoch == '1);

    logic                wr_en;
    logic [AB-1:0]       wr_addr;
    logic [7:0]          wr_pix;
    logic [HIT_BITS-1:0] wr_hit;
    logic [EB-1:0]       wr_ep;
    logic [7:0]          new_pix;
    logic [HIT_BITS-1:0] new_hit;
    logic                do_write;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pix_mem[wr_addr] <= wr_pix;
            r_hit_mem[wr_addr] <= wr_hit;
            r_ep_mem[wr_addr]  <= wr_ep;
        end
        if (i_cmd.rd_issue) begin
            r_rd_pix <= r_pix_mem[r_addr];
            r_rd_hit <= r_hit_mem[r_addr];
            r_rd_ep  <= r_ep_mem[r_addr];
        end
    end

    logic [7:0]          old_pix;
    logic [HIT_BITS-1:0] old_hit;
    assign old_pix = (r_rd_ep == r_epoch) ? r_rd_pix : 8'd0;
    assign old_hit = (r_rd_ep == r_epoch) ? r_rd_hit : '0;

    logic in_map;
    assign in_map = r_in_store && (r_item.column != 8'd0) && (r_item.row != 8'd0)
                 && ({1'b0, r_item.column} < r_map_width)
                 && ({1'b0, r_item.row} < r_map_height);
    assign do_write = (r_item.operation == OP_UPDATE) && in_map
                   && (r_item.point_index > r_near_skip);

    assign new_hit = (old_hit == HIT_MAX) ? old_hit : old_hit + 1'b1;

    // Serial restoring divider, one quotient bit per cycle for both quotients.
    logic [NB-1:0]  r_n;
    logic [DB-1:0]  r_num_a, r_num_b;
    logic [NB-1:0]  r_rem_a, r_rem_b;
    logic [CB-1:0]  r_div_cnt;
    logic           r_div_busy;
    logic [NB:0]    tr_a, tr_b;
    logic [7:0]     v_bin;

    assign v_bin = (r_item.raw_intensity > r_threshold) ? 8'hFF : 8'h00;
    assign tr_a = {r_rem_a, r_num_a[DB-1]} - {1'b0, r_n};
    assign tr_b = {r_rem_b, r_num_b[DB-1]} - {1'b0, r_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= CB'(DB - 1);
            r_n        <= NB'(new_hit) + 1'b1;
            r_num_a    <= DB'(v_bin);
            r_num_b    <= DB'(old_pix) * DB'(new_hit);
            r_rem_a    <= '0;
            r_rem_b    <= '0;
        end else if (r_div_busy) begin
            if (!tr_a[NB]) begin
                r_rem_a <= tr_a[NB-1:0];
                r_num_a <= {r_num_a[DB-2:0], 1'b1};
            end else begin
                r_rem_a <= {r_rem_a[NB-2:0], r_num_a[DB-1]};
                r_num_a <= {r_num_a[DB-2:0], 1'b0};
            end
            if (!tr_b[NB]) begin
                r_rem_b <= tr_b[NB-1:0];
                r_num_b <= {r_num_b[DB-2:0], 1'b1};
            end else begin
                r_rem_b <= {r_rem_b[NB-2:0], r_num_b[DB-1]};
                r_num_b <= {r_num_b[DB-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt - 1'b1;
            if (r_div_cnt == '0) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    assign o_status.div_done = !r_div_busy && !i_cmd.div_start;
    assign new_pix = 8'(r_num_a + r_num_b);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_pix  = new_pix;
        wr_hit  = new_hit;
        wr_ep   = r_epoch;
        if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_pix  = '0;
            wr_hit  = '0;
        end else if (i_cmd.wr_issue && do_write) begin
            wr_en = 1'b1;
        end
    end

    logic [15:0] cnt_inc;
    logic        warm_next, ready;
    assign cnt_inc   = (r_counter == 16'hFFFF) ? r_counter : r_counter + 1'b1;
    assign warm_next = r_warm || (cnt_inc > r_warmup);
    assign ready     = warm_next && (cnt_inc >= r_interval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_warm    <= 1'b0;
        end else if (i_cmd.finish) begin
            if (r_item.operation == OP_UPDATE) begin
                r_counter <= ready ? 16'd0 : cnt_inc;
                r_warm    <= warm_next;
            end else if (r_item.operation == OP_CLEAR) begin
                r_counter <= '0;
                r_warm    <= 1'b0;
            end
        end
    end

    always_comb begin
        o_result = '0;
        case (r_item.operation)
            OP_UPDATE: begin
                if (do_write) begin
                    o_result.pixel_value   = new_pix;
                    o_result.hit_count     = 16'(new_hit);
                    o_result.pixel_written = 1'b1;
                end
                o_result.map_ready = ready;
            end
            OP_READ: begin
                if (r_in_store) begin
                    o_result.pixel_value = old_pix;
                    o_result.hit_count   = 16'(old_hit);
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
